>>> hdl/mwm_pkg.sv
package mwm_pkg;

    localparam int WHEELS  = 4;
    localparam int CMD_W   = 16;
    localparam int SUM_W   = 18;
    localparam int MAG_W   = 17;
    localparam int NUM_W   = 32;
    localparam int QUO_W   = 15;
    localparam int LATENCY = QUO_W + 4;

    localparam logic [MAG_W-1:0] MIX_ONE = 17'd32768;

    localparam int FL = 0;
    localparam int FR = 1;
    localparam int BL = 2;
    localparam int BR = 3;

    typedef struct packed {
        logic signed [CMD_W-1:0] strafe_cmd;
        logic signed [CMD_W-1:0] forward_cmd;
        logic signed [CMD_W-1:0] turn_cmd;
    } cmd_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] front_left;
        logic signed [CMD_W-1:0] front_right;
        logic signed [CMD_W-1:0] back_left;
        logic signed [CMD_W-1:0] back_right;
    } wheel_t;

    // word holds {partial remainder, numerator bits left / quotient bits so far}
    typedef struct packed {
        logic                              valid;
        logic [MAG_W-1:0]                  denom;
        logic [WHEELS-1:0]                 neg;
        logic [WHEELS-1:0][NUM_W-1:0]      word;
    } div_t;

    function automatic logic signed [SUM_W-1:0] sext_sum(input logic signed [CMD_W-1:0] v);
        sext_sum = {{(SUM_W-CMD_W){v[CMD_W-1]}}, v};
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] a;
        a = v[SUM_W-1] ? -v : v;
        mag_of = a[MAG_W-1:0];
    endfunction

endpackage

>>> hdl/mwm_mix.sv
module mwm_mix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  mwm_pkg::cmd_t   cmd,
    output mwm_pkg::div_t   mix
);

    logic                                                   s1_valid_reg;
    logic signed [mwm_pkg::WHEELS-1:0][mwm_pkg::SUM_W-1:0]  sum_reg;
    logic signed [mwm_pkg::WHEELS-1:0][mwm_pkg::SUM_W-1:0]  sum_next;

    logic                                                   s2_valid_reg;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0]         mag_reg;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0]         mag_next;
    logic [mwm_pkg::WHEELS-1:0]                             neg_reg;
    logic [mwm_pkg::WHEELS-1:0]                             neg_next;
    logic [1:0][mwm_pkg::MAG_W-1:0]                         pmax_reg;
    logic [1:0][mwm_pkg::MAG_W-1:0]                         pmax_next;

    logic                                                   s3_valid_reg;
    logic [mwm_pkg::MAG_W-1:0]                              denom_reg;
    logic [mwm_pkg::MAG_W-1:0]                              denom_next;
    logic [mwm_pkg::WHEELS-1:0]                             neg3_reg;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::NUM_W-1:0]         num_reg;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::NUM_W-1:0]         num_next;
    logic [mwm_pkg::MAG_W-1:0]                              maxabs;

    logic signed [mwm_pkg::SUM_W-1:0] x;
    logic signed [mwm_pkg::SUM_W-1:0] y;
    logic signed [mwm_pkg::SUM_W-1:0] t;

    always_comb
    begin
        x = mwm_pkg::sext_sum(cmd.strafe_cmd);
        y = mwm_pkg::sext_sum(cmd.forward_cmd);
        t = mwm_pkg::sext_sum(cmd.turn_cmd);
        sum_next[mwm_pkg::FL] = y + x + t;
        sum_next[mwm_pkg::FR] = y - x - t;
        sum_next[mwm_pkg::BL] = y - x + t;
        sum_next[mwm_pkg::BR] = y + x - t;
    end

    always_comb
    begin
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            mag_next[i] = mwm_pkg::mag_of(sum_reg[i]);
            neg_next[i] = sum_reg[i][mwm_pkg::SUM_W-1];
        end
        pmax_next[0] = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
        pmax_next[1] = (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
    end

    always_comb
    begin
        maxabs     = (pmax_reg[0] > pmax_reg[1]) ? pmax_reg[0] : pmax_reg[1];
        denom_next = (maxabs > mwm_pkg::MIX_ONE) ? maxabs : mwm_pkg::MIX_ONE;
        // mag * 32767 as (mag << 15) - mag
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            num_next[i] = {mag_reg[i][mwm_pkg::NUM_W-mwm_pkg::QUO_W-1:0], {mwm_pkg::QUO_W{1'b0}}}
                        - {{(mwm_pkg::NUM_W-mwm_pkg::MAG_W){1'b0}}, mag_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= load;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        pmax_reg  <= pmax_next;
        denom_reg <= denom_next;
        neg3_reg  <= neg_reg;
        num_reg   <= num_next;
    end

    assign mix.valid = s3_valid_reg;
    assign mix.denom = denom_reg;
    assign mix.neg   = neg3_reg;
    assign mix.word  = num_reg;

    a_denom_floor: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> denom_reg >= mwm_pkg::MIX_ONE)
        else $error("denominator below full scale");

    a_num_fits: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> num_reg[mwm_pkg::FL][mwm_pkg::NUM_W-1:mwm_pkg::QUO_W] < denom_reg)
        else $error("quotient would overflow");

endmodule

>>> hdl/mwm_div_stage.sv
module mwm_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  mwm_pkg::div_t   d_in,
    output mwm_pkg::div_t   d_out
);

    logic                                                valid_reg;
    logic [mwm_pkg::MAG_W-1:0]                           denom_reg;
    logic [mwm_pkg::WHEELS-1:0]                          neg_reg;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::NUM_W-1:0]      word_reg;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::NUM_W-1:0]      word_next;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W:0]        trial;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W:0]        diff;
    logic [mwm_pkg::WHEELS-1:0]                          qbit;

    always_comb
    begin
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            trial[i] = d_in.word[i][mwm_pkg::NUM_W-1:mwm_pkg::QUO_W-1];
            diff[i]  = trial[i] - {1'b0, d_in.denom};
            qbit[i]  = trial[i] >= {1'b0, d_in.denom};
            // shift in the next numerator bit, shift the quotient bit in at the bottom
            word_next[i] = {qbit[i] ? diff[i][mwm_pkg::MAG_W-1:0] : trial[i][mwm_pkg::MAG_W-1:0],
                            d_in.word[i][mwm_pkg::QUO_W-2:0], qbit[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= d_in.valid;
    end

    always_ff @(posedge clk)
    begin
        denom_reg <= d_in.denom;
        neg_reg   <= d_in.neg;
        word_reg  <= word_next;
    end

    assign d_out.valid = valid_reg;
    assign d_out.denom = denom_reg;
    assign d_out.neg   = neg_reg;
    assign d_out.word  = word_reg;

    a_rem_below_denom: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> word_reg[mwm_pkg::BR][mwm_pkg::NUM_W-1:mwm_pkg::QUO_W] < denom_reg)
        else $error("partial remainder not below divisor");

endmodule

>>> hdl/mecanum_wheel_mixer.sv
// A command beat taken with start passes the mix sum, magnitude and scale registers, each divider
// stage and the output register before its result beat shows with done.
// Throughput: one command beat per cycle; busy stays low.
// Stages: mix sums, magnitudes, normalize and scale, 15 divider bits, sign and output.
// The receiver cannot stall: each result beat shows on result for one cycle with done.
// Reset clears every valid bit and done; payload registers are not reset.
module mecanum_wheel_mixer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mwm_pkg::cmd_t     cmd,
    output logic              done,
    output mwm_pkg::wheel_t   result
);

    mwm_pkg::div_t chain [0:mwm_pkg::QUO_W];

    logic                                                      done_reg;
    logic signed [mwm_pkg::WHEELS-1:0][mwm_pkg::CMD_W-1:0]     wheel_reg;
    logic signed [mwm_pkg::WHEELS-1:0][mwm_pkg::CMD_W-1:0]     wheel_next;
    logic [mwm_pkg::CMD_W-1:0]                                 quo;

    assign busy = 1'b0;

    mwm_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (start),
        .cmd   (cmd),
        .mix   (chain[0])
    );

    for (genvar s = 0; s < mwm_pkg::QUO_W; s++)
    begin : g_div
        mwm_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .d_in  (chain[s]),
            .d_out (chain[s+1])
        );
    end

    always_comb
    begin
        quo = '0;
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            quo           = {1'b0, chain[mwm_pkg::QUO_W].word[i][mwm_pkg::QUO_W-1:0]};
            wheel_next[i] = chain[mwm_pkg::QUO_W].neg[i] ? -$signed(quo) : $signed(quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain[mwm_pkg::QUO_W].valid;
    end

    always_ff @(posedge clk)
    begin
        wheel_reg <= wheel_next;
    end

    assign done               = done_reg;
    assign result.front_left  = wheel_reg[mwm_pkg::FL];
    assign result.front_right = wheel_reg[mwm_pkg::FR];
    assign result.back_left   = wheel_reg[mwm_pkg::BL];
    assign result.back_right  = wheel_reg[mwm_pkg::BR];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##19 done)
        else $error("result beat missing after command beat");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.front_left != 16'sh8000 && result.front_right != 16'sh8000
              && result.back_left != 16'sh8000 && result.back_right != 16'sh8000)
        else $error("wheel output outside full scale");

endmodule

>>> sim/mecanum_wheel_mixer_tb.sv
module mecanum_wheel_mixer_tb;

    localparam int WHEEL_FULL  = 32767;
    localparam int PHASE_BEATS = 275;

    class wheel_scoreboard;

        mwm_pkg::wheel_t pending_wheels[$];
        int     errors;
        int     reported;

        function new();
            errors   = 0;
            reported = 0;
        endfunction

        function mwm_pkg::wheel_t mix_wheels(input mwm_pkg::cmd_t c);
            int              x;
            int              y;
            int              t;
            int              sums[mwm_pkg::WHEELS];
            int              mags[mwm_pkg::WHEELS];
            int              peak;
            int              denom;
            longint          scaled;
            logic [15:0]     drive[mwm_pkg::WHEELS];
            mwm_pkg::wheel_t w;
            x = c.strafe_cmd;
            y = c.forward_cmd;
            t = c.turn_cmd;
            sums[mwm_pkg::FL] = y + x + t;
            sums[mwm_pkg::FR] = y - x - t;
            sums[mwm_pkg::BL] = y - x + t;
            sums[mwm_pkg::BR] = y + x - t;
            peak = 0;
            for (int i = 0; i < mwm_pkg::WHEELS; i++)
            begin
                mags[i] = (sums[i] < 0) ? -sums[i] : sums[i];
                if (mags[i] > peak)
                    peak = mags[i];
            end
            denom = (peak > int'(mwm_pkg::MIX_ONE)) ? peak : int'(mwm_pkg::MIX_ONE);
            for (int i = 0; i < mwm_pkg::WHEELS; i++)
            begin
                scaled = (longint'(mags[i]) * WHEEL_FULL) / denom;
                if (sums[i] < 0)
                    scaled = -scaled;
                drive[i] = scaled[15:0];
            end
            w.front_left  = drive[mwm_pkg::FL];
            w.front_right = drive[mwm_pkg::FR];
            w.back_left   = drive[mwm_pkg::BL];
            w.back_right  = drive[mwm_pkg::BR];
            return w;
        endfunction

        function void note_command(input mwm_pkg::cmd_t c);
            pending_wheels.push_back(mix_wheels(c));
        endfunction

        function void check_wheels(input mwm_pkg::wheel_t got);
            mwm_pkg::wheel_t     want;
            logic signed [15:0]  want_f[mwm_pkg::WHEELS];
            logic signed [15:0]  got_f[mwm_pkg::WHEELS];
            string               names[mwm_pkg::WHEELS];
            names = '{"front_left", "front_right", "back_left", "back_right"};
            if (pending_wheels.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected wheel beat: fl=%0d fr=%0d bl=%0d br=%0d",
                             got.front_left, got.front_right, got.back_left, got.back_right);
                end
                return;
            end
            want = pending_wheels.pop_front();
            want_f = '{want.front_left, want.front_right, want.back_left, want.back_right};
            got_f  = '{got.front_left, got.front_right, got.back_left, got.back_right};
            for (int i = 0; i < mwm_pkg::WHEELS; i++)
            begin
                if (got_f[i] !== want_f[i])
                begin
                    errors++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("%s mismatch: expected %0d, got %0d",
                                 names[i], want_f[i], got_f[i]);
                    end
                end
            end
        endfunction

    endclass

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    mwm_pkg::cmd_t   cmd;
    logic            done;
    mwm_pkg::wheel_t result;

    wheel_scoreboard sb;

    mecanum_wheel_mixer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("mecanum_wheel_mixer test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(cmd);
            if (done)
                sb.check_wheels(result);
        end
    end

    task automatic send_cmd(input mwm_pkg::cmd_t c, input int idle_pct);
        @(negedge clk);
        while ($urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_fields(input int x, input int y, input int t);
        mwm_pkg::cmd_t c;
        c.strafe_cmd  = x[15:0];
        c.forward_cmd = y[15:0];
        c.turn_cmd    = t[15:0];
        send_cmd(c, 0);
    endtask

    task automatic drain_wheels();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_wheels.size() != 0)
            @(posedge clk);
    endtask

    function automatic mwm_pkg::cmd_t random_cmd();
        mwm_pkg::cmd_t c;
        int   x;
        int   y;
        int   t;
        int   corner[6];
        corner = '{-32768, -32767, -1, 0, 1, 32767};
        case ($urandom_range(0, 3))
            0:
            begin
                x = $urandom_range(0, 24000) - 12000;
                y = $urandom_range(0, 24000) - 12000;
                t = $urandom_range(0, 24000) - 12000;
            end
            1:
            begin
                x = $urandom_range(0, 16384);
                y = $urandom_range(0, 16384);
                t = 32768 - x - y + $urandom_range(0, 4) - 2;
                if (t > 32767)
                    t = 32767;
                if ($urandom_range(0, 1) == 1)
                begin
                    x = -x;
                    y = -y;
                    t = -t;
                end
            end
            2:
            begin
                x = corner[$urandom_range(0, 5)];
                y = corner[$urandom_range(0, 5)];
                t = corner[$urandom_range(0, 5)];
            end
            default:
            begin
                x = $urandom();
                y = $urandom();
                t = $urandom();
            end
        endcase
        c.strafe_cmd  = x[15:0];
        c.forward_cmd = y[15:0];
        c.turn_cmd    = t[15:0];
        return c;
    endfunction

    initial
    begin
        int idle_plan[4];
        idle_plan = '{0, 83, 0, 28};
        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send_fields(0, 0, 0);
        send_fields(32767, 32767, 32767);
        send_fields(-32768, -32768, -32768);
        send_fields(32767, -32768, 32767);
        send_fields(-32768, 32767, -32768);
        send_fields(32767, 0, 0);
        send_fields(0, 32767, 0);
        send_fields(0, 0, 32767);
        send_fields(-32768, 0, 0);
        send_fields(0, -32768, 0);
        send_fields(0, 0, -32768);
        send_fields(1, 32767, 0);
        send_fields(2, 32767, 0);
        send_fields(0, 32767, 1);
        send_fields(-1, -32767, -1);
        send_fields(1, 1, 1);
        send_fields(-1, 0, 0);
        send_fields(10000, 10000, 10000);
        send_fields(-12345, 23456, -7890);
        drain_wheels();

        foreach (idle_plan[p])
        begin
            for (int n = 0; n < PHASE_BEATS; n++)
                send_cmd(random_cmd(), idle_plan[p]);
            drain_wheels();
        end

        repeat (mwm_pkg::LATENCY + 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending_wheels.size() == 0)
            $display("mecanum_wheel_mixer test passed");
        else
            $display("mecanum_wheel_mixer test failed");
        $finish;
    end

endmodule

>>> files.f
hdl/mwm_pkg.sv
hdl/mwm_mix.sv
hdl/mwm_div_stage.sv
hdl/mecanum_wheel_mixer.sv
sim/mecanum_wheel_mixer_tb.sv
